FILE: rtl/adapter_tail_overlap_detector_top_macros.svh
// Assertion macros for the adapter tail overlap detector checker.
// Used by atod_check.sv; no other dependencies.
`ifndef ADAPTER_TAIL_OVERLAP_DETECTOR_TOP_MACROS_SVH
`define ADAPTER_TAIL_OVERLAP_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ATOD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atod check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during reset.
`define ATOD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atod check failed: next-cycle rule");

`endif

FILE: rtl/atod_pkg.sv
// Package for the adapter tail overlap detector: adapter sequences,
// register map, reset values and the structs passed between modules.
package atod_pkg;

	localparam int SEQ_CHARS = 19;
	localparam int CHAR_W    = 8;
	localparam int OVL_W     = 5;

	// Register indexes
	localparam logic [1:0] REG_MIN_OVERLAP = 2'd0;

	localparam logic [OVL_W-1:0] MIN_OVERLAP_RESET = 5'd6;

	// Adapter 0: CTGTCTCTTATACACATCT, adapter 1: AGATGTGTATAAGAGACAG
	localparam logic [CHAR_W-1:0] ADAPTER_SEQ [2][SEQ_CHARS] = '{
		'{"C","T","G","T","C","T","C","T","T","A","T","A","C","A","C","A","T","C","T"},
		'{"A","G","A","T","G","T","G","T","A","T","A","A","G","A","G","A","C","A","G"}
	};

	typedef struct packed {
		logic accept;
		logic last;
	} hist_ctl_t;

	typedef struct packed {
		logic [OVL_W-1:0] overlap;
		logic             sel;
	} atod_result_t;

endpackage

FILE: rtl/atod_hist.sv
// Base history shift register and the stage-1 window snapshot.
// Depends on atod_pkg.
module atod_hist #(
	parameter int ADAPTER_LEN = 19,
	parameter int SEEN_W      = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  atod_pkg::hist_ctl_t        ctl,
	input  logic [atod_pkg::CHAR_W-1:0] base_char,
	output logic [atod_pkg::CHAR_W-1:0] window_s1 [ADAPTER_LEN],
	output logic [SEEN_W-1:0]          seen_s1
);
	import atod_pkg::*;

	logic [CHAR_W-1:0] hist_q   [ADAPTER_LEN];
	logic [CHAR_W-1:0] win_next [ADAPTER_LEN];
	logic [SEEN_W-1:0] seen_q, seen_next;

	// newest base at the top index
	always_comb begin
		for (int k = 0; k < ADAPTER_LEN - 1; k++) begin
			win_next[k] = hist_q[k+1];
		end
		win_next[ADAPTER_LEN-1] = base_char;
		seen_next = (seen_q == SEEN_W'(ADAPTER_LEN)) ? seen_q : seen_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ADAPTER_LEN; k++) begin
				hist_q[k] <= '0;
			end
			seen_q <= '0;
		end else if (ctl.accept) begin
			for (int k = 0; k < ADAPTER_LEN; k++) begin
				hist_q[k] <= ctl.last ? '0 : win_next[k];
			end
			seen_q <= ctl.last ? '0 : seen_next;
		end
	end

	// snapshot of the window as it stands after this base
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			window_s1 <= win_next;
			seen_s1   <= seen_next;
		end
	end

endmodule

FILE: rtl/atod_match.sv
// Parallel suffix/prefix compare against both adapters; longest match of adapter 0, else of adapter 1.
// Depends on atod_pkg.
module atod_match #(
	parameter int ADAPTER_LEN = 19,
	parameter int SEEN_W      = 5
) (
	input  logic [atod_pkg::CHAR_W-1:0] window [ADAPTER_LEN],
	input  logic [SEEN_W-1:0]           seen,
	input  logic [atod_pkg::OVL_W-1:0]  min_ov,
	output atod_pkg::atod_result_t      res
);
	import atod_pkg::*;

	localparam int MAXL = (ADAPTER_LEN < SEQ_CHARS) ? ADAPTER_LEN : SEQ_CHARS;

	logic [MAXL:1]    hit0, hit1;
	logic [OVL_W-1:0] best0, best1;

	always_comb begin
		logic ok0, ok1;
		hit0 = '0;
		hit1 = '0;
		for (int len = 1; len <= MAXL; len++) begin
			ok0 = 1'b1;
			ok1 = 1'b1;
			for (int i = 0; i < len; i++) begin
				if (window[ADAPTER_LEN-len+i] != ADAPTER_SEQ[0][i]) ok0 = 1'b0;
				if (window[ADAPTER_LEN-len+i] != ADAPTER_SEQ[1][i]) ok1 = 1'b0;
			end
			// length must fit the read and reach the minimum overlap
			if ((6'(len) <= 6'(seen)) && (6'(len) >= {1'b0, min_ov})) begin
				hit0[len] = ok0;
				hit1[len] = ok1;
			end
		end
	end

	// longest hit per adapter wins: later (longer) lengths overwrite; any adapter 0 hit beats adapter 1
	always_comb begin
		best0 = '0;
		best1 = '0;
		for (int len = 1; len <= MAXL; len++) begin
			if (hit0[len]) best0 = OVL_W'(len);
			if (hit1[len]) best1 = OVL_W'(len);
		end
		priority if (min_ov == '0) begin
			res = '0;
		end else if (|hit0) begin
			res.overlap = best0;
			res.sel     = 1'b0;
		end else if (|hit1) begin
			res.overlap = best1;
			res.sel     = 1'b1;
		end else begin
			res = '0;
		end
	end

endmodule

FILE: rtl/adapter_tail_overlap_detector_top.sv
// A last base's window is registered into stage 1, then its result into the output register on m_*.
// Throughput: one base per cycle; s_tready drops only while a pending result
// in stage 1 cannot move into the full, stalled output register.
// Reset (arst_n low, asynchronous): history and base count cleared,
// min_overlap back to 6, no result pending.
module adapter_tail_overlap_detector_top #(
	parameter int ADAPTER_LEN = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	// input base stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] base_char
	input  logic        s_tlast,   // last_base
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] tail_info, [10:6] overlap_len, [15:11] zero
	output logic [0:0]  m_tuser,   // [0] adapter_sel
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import atod_pkg::*;

	// base count must hold ADAPTER_LEN itself
	localparam int SEEN_W = $clog2(ADAPTER_LEN + 1);

	logic [OVL_W-1:0]  min_ov_q;
	logic [CHAR_W-1:0] window_s1 [ADAPTER_LEN];
	logic [SEEN_W-1:0] seen_s1;
	logic              valid_s1;
	atod_result_t      res;
	atod_result_t      out_q;
	logic              out_valid_q;
	logic              advance;
	hist_ctl_t         hctl;

	// --- configuration ---
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ov_q <= MIN_OVERLAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_MIN_OVERLAP)) begin
			min_ov_q <= pwdata[OVL_W-1:0];
		end
	end

	assign prdata = (paddr == REG_MIN_OVERLAP) ? {{(32-OVL_W){1'b0}}, min_ov_q} : '0;

	// --- flow control ---
	// output register frees up when empty or being taken
	assign advance  = !out_valid_q || m_tready;
	// stage 1 only holds a request for a last base; it drains when advance is high
	assign s_tready = !valid_s1 || advance;

	assign hctl.accept = s_tvalid && s_tready;
	assign hctl.last   = s_tlast;

	// --- history and window snapshot ---
	atod_hist #(
		.ADAPTER_LEN(ADAPTER_LEN),
		.SEEN_W     (SEEN_W)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hctl),
		.base_char(s_tdata),
		.window_s1(window_s1),
		.seen_s1  (seen_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hctl.accept) begin
			valid_s1 <= s_tlast;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// --- compare against both adapters ---
	atod_match #(
		.ADAPTER_LEN(ADAPTER_LEN),
		.SEEN_W     (SEEN_W)
	) u_match (
		.window(window_s1),
		.seen  (seen_s1),
		.min_ov(min_ov_q),
		.res   (res)
	);

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

	// tail_info = overlap * 2 + adapter index
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {5'b0, out_q.overlap, out_q.overlap, out_q.sel};
	assign m_tuser[0] = out_q.sel;

endmodule

FILE: rtl/atod_check.sv
// Port-level checker for the adapter tail overlap detector, bound to the top.
// Depends on adapter_tail_overlap_detector_top_macros.svh.
`include "adapter_tail_overlap_detector_top_macros.svh"

module atod_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// stalled result holds
	`ATOD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// packed field agrees with its parts
	`ATOD_ASSERT_IMPL(a_tail_pack, m_tvalid, m_tdata[5:0] == {m_tdata[10:6], m_tuser[0]})
	// no overlap means no adapter
	`ATOD_ASSERT_IMPL(a_zero_sel, m_tvalid && (m_tdata[10:6] == 5'd0), m_tuser[0] == 1'b0)
	// overlap bounded by adapter length, padding zero
	`ATOD_ASSERT_IMPL(a_ovl_range, m_tvalid, (m_tdata[10:6] <= 5'd19) && (m_tdata[15:11] == 5'd0))

endmodule

bind adapter_tail_overlap_detector_top atod_check u_atod_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

FILE: test/tb_top.sv
// Self-checking bench for adapter_tail_overlap_detector_top: streams reads, predicts
// the adapter overlap of each read, and compares every result. Needs rtl/atod_pkg.sv
// and the top-level RTL.
`timescale 1ns / 100ps

module tb_top;
	import atod_pkg::*;

	localparam int TAIL_LEN    = 19;            // history depth of the block
	localparam int PHASE_BASES = 112;           // random bases per min_overlap setting
	localparam int DRAIN_WAIT  = 4;             // spare cycles waited after the last expected result
	localparam int CYCLE_LIMIT = 200000;        // far beyond the slowest legal run

	// Our own copies of both adapters, first base in the top byte
	localparam bit [8*TAIL_LEN-1:0] ADAPTER_A = "CTGTCTCTTATACACATCT";
	localparam bit [8*TAIL_LEN-1:0] ADAPTER_B = "AGATGTGTATAAGAGACAG";

	typedef struct packed {
		bit [5:0] tail_info;
		bit [4:0] overlap_len;
		bit       adapter_sel;
	} tail_t;

	typedef struct packed {
		bit [7:0] ch;
		bit       last_b;
		bit       typed;      // expected result given below instead of predicted
		tail_t    res;
	} dir_row_t;

	// Directed reads. Typed rows: one-base reads below min_overlap give zero;
	// an exact six-base adapter prefix at the reset minimum gives overlap 6.
	localparam dir_row_t DIRECTED_READS [22] = '{
		'{8'hFF, 1'b1, 1'b1, '{6'd0,  5'd0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{6'd0,  5'd0, 1'b0}},
		'{"C",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"G",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"C",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b1, 1'b1, '{6'd12, 5'd6, 1'b0}},
		'{"A",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"G",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"A",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"G",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b1, 1'b1, '{6'd13, 5'd6, 1'b1}},
		'{8'hFF, 1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"C",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"G",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"C",   1'b0, 1'b0, '{6'd0,  5'd0, 1'b0}},
		'{"T",   1'b1, 1'b0, '{6'd0,  5'd0, 1'b0}}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] base_char
	logic        s_tlast;    // last_base
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [5:0] tail_info, [10:6] overlap_len, [15:11] zero
	logic [0:0]  m_tuser;    // [0] adapter_sel
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: base history (newest at the top), bases seen, register copy
	bit [7:0]    hist [TAIL_LEN];
	int          bases_seen;
	bit [4:0]    min_ovl_cfg;

	tail_t       pending_tails [$];   // expected results, oldest first
	int          mismatches;
	int          cycle_count;
	bit          idle_en;             // sender may insert gaps
	bit          stall_en;            // receiver may drop m_tready

	adapter_tail_overlap_detector_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run guard: a hang anywhere ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[adapter_tail_overlap_detector_top] ERROR");
			$finish;
		end
	end

	function automatic bit [7:0] adapter_base(bit sel, int idx);
		bit [8*TAIL_LEN-1:0] seq;
		seq = sel ? ADAPTER_B : ADAPTER_A;
		return seq[8*(TAIL_LEN-1-idx) +: 8];
	endfunction

	// Shift in one base; on the last base search adapter A, then adapter B,
	// from the longest suffix down to min_overlap, then clear the history.
	function automatic bit predict_tail(bit [7:0] ch, bit last_b, output tail_t res);
		int  len;
		int  s;
		int  i;
		bit  found;
		bit  hit;
		res = '0;
		for (i = 0; i < TAIL_LEN - 1; i++)
			hist[i] = hist[i+1];
		hist[TAIL_LEN-1] = ch;
		if (bases_seen < TAIL_LEN)
			bases_seen++;
		if (!last_b)
			return 1'b0;
		found = 1'b0;
		// zero minimum: the empty overlap wins at once, result stays zero
		if (bases_seen >= min_ovl_cfg && min_ovl_cfg != 0) begin
			for (s = 0; s < 2 && !found; s++) begin
				for (len = bases_seen; len >= min_ovl_cfg && len > 0 && !found; len--) begin
					hit = 1'b1;
					for (i = 0; i < len; i++)
						if (hist[TAIL_LEN-len+i] != adapter_base(s[0], i))
							hit = 1'b0;
					if (hit) begin
						found = 1'b1;
						res.overlap_len = len[4:0];
						res.adapter_sel = s[0];
					end
				end
			end
		end
		res.tail_info = {res.overlap_len, res.adapter_sel};
		for (i = 0; i < TAIL_LEN; i++)
			hist[i] = 8'h00;
		bases_seen = 0;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	// One base request. Ready is sampled at the falling edge, where the
	// handshake signals are settled; the base is taken at the next rising edge.
	task automatic send_base(bit [7:0] ch, bit last_b, bit gappy, bit use_typed,
			tail_t typed_res);
		bit    rdy;
		tail_t res;
		if (gappy && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last_b;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		if (predict_tail(ch, last_b, res)) begin
			if (use_typed)
				res = typed_res;
			pending_tails = {pending_tails, res};
		end
	endtask

	function automatic bit [7:0] rand_nucleotide();
		case ($urandom_range(0, 3))
			0: return "A";
			1: return "C";
			2: return "G";
			default: return "T";
		endcase
	endfunction

	// One random read. Most reads end in an adapter prefix of random length,
	// some with one base spoiled, some pure noise, some with a short adapter A
	// prefix stacked on an adapter B prefix.
	task automatic send_read(output int n);
		bit [7:0] bases [$];
		int       kind;
		int       pre;
		int       len;
		int       i;
		bit       sel;
		bit       gappy;
		kind  = $urandom_range(0, 9);
		sel   = 1'($urandom_range(0, 1));
		len   = $urandom_range(1, TAIL_LEN);
		pre   = $urandom_range(0, 12);
		gappy = idle_en && $urandom_range(0, 1);
		case (kind)
			0, 1, 2, 3, 4, 5: begin
				for (i = 0; i < pre; i++)
					bases = {bases, rand_nucleotide()};
				for (i = 0; i < len; i++)
					bases = {bases, adapter_base(sel, i)};
				if (kind == 5)
					bases[pre + $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
			end
			6, 7: begin
				for (i = 0; i < $urandom_range(1, 30); i++)
					bases = {bases, rand_nucleotide()};
			end
			8: begin
				for (i = 0; i < $urandom_range(1, 25); i++)
					bases = {bases, 8'($urandom_range(0, 255))};
			end
			default: begin
				for (i = 0; i < len; i++)
					bases = {bases, adapter_base(1'b1, i)};
				for (i = 0; i < $urandom_range(1, 5); i++)
					bases = {bases, adapter_base(1'b0, i)};
			end
		endcase
		n = bases.size();
		for (i = 0; i < n; i++)
			send_base(bases[i], i == n - 1, gappy, 1'b0, '0);
	endtask

	// Let every expected result arrive, then a few spare cycles
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_tails.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// APB write of min_overlap: setup cycle, then access until pready
	task automatic write_min_overlap(bit [4:0] value);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 2'(4 * REG_MIN_OVERLAP);
		pwdata  <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		min_ovl_cfg = value;
	endtask

	// Result side: m_tready in random stall bursts, none when stall_en is off
	initial begin
		m_tready <= 1'b0;
		repeat (13) @(posedge clk);
		forever begin
			if (stall_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Result checker: a result is taken at the rising edge after this falling
	// edge, since both sides only change right after a rising edge.
	always @(negedge clk) begin : result_check
		tail_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tails.size() == 0) begin
				flag_mismatch("result with none pending", 0, m_tdata);
			end else begin
				want = pending_tails.pop_front();
				if (m_tdata[5:0] != want.tail_info)
					flag_mismatch("tail_info", want.tail_info, m_tdata[5:0]);
				if (m_tdata[10:6] != want.overlap_len)
					flag_mismatch("overlap_len", want.overlap_len, m_tdata[10:6]);
				if (m_tuser[0] != want.adapter_sel)
					flag_mismatch("adapter_sel", want.adapter_sel, m_tuser[0]);
				if (m_tdata[15:11] != 5'd0)
					flag_mismatch("tdata pad", 0, m_tdata[15:11]);
			end
		end
	end

	// Main sequence: reset, directed reads at the reset minimum, then one
	// phase of random reads per min_overlap setting (extremes, zero, out of
	// range, a random one). The last phase runs with no gaps and no stalls.
	initial begin : main_seq
		int       p;
		int       n;
		int       done;
		bit [4:0] phase_min [7];
		phase_min = '{MIN_OVERLAP_RESET, 5'd1, 5'd19, 5'd0, 5'd31, 5'd20,
			5'($urandom_range(2, 18))};
		arst_n      = 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= 8'h00;
		s_tlast     <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= 2'd0;
		pwdata      <= 32'd0;
		mismatches  = 0;
		bases_seen  = 0;
		min_ovl_cfg = MIN_OVERLAP_RESET;
		idle_en     = 1'b1;
		stall_en    = 1'b1;
		foreach (hist[i])
			hist[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_READS[i])
			send_base(DIRECTED_READS[i].ch, DIRECTED_READS[i].last_b, 1'b1,
				DIRECTED_READS[i].typed, DIRECTED_READS[i].res);

		for (p = 0; p < 7; p++) begin
			if (p > 0) begin
				drain_results();
				write_min_overlap(phase_min[p]);
			end
			if (p == 6) begin
				idle_en  = 1'b0;
				stall_en = 1'b0;
			end
			done = 0;
			while (done < PHASE_BASES) begin
				send_read(n);
				done += n;
			end
		end

		drain_results();
		if (mismatches == 0) begin
			$display("[adapter_tail_overlap_detector_top] OK");
		end else begin
			$display("[adapter_tail_overlap_detector_top] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/atod_pkg.sv
rtl/atod_hist.sv
rtl/atod_match.sv
rtl/adapter_tail_overlap_detector_top.sv
rtl/atod_check.sv
test/tb_top.sv
